[sv/rqf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rqf_pkg
// Shared types and constants of the radius query falloff unit.
// ----------------------------------------------------------------------------
package rqf_pkg;

    localparam int COORD_W  = 16;              // field width of positions
    localparam int EMIS_W   = 8;               // Q0.8 emission / strength
    localparam int D2_W     = 2 * COORD_W + 2; // squared distance, even width
    localparam int SQ_STEPS = D2_W / 2;        // root bits, one step each
    localparam int NUM_W    = EMIS_W + COORD_W;

    // configuration register indexes
    localparam logic [1:0] REG_CENTER_X = 2'd0;
    localparam logic [1:0] REG_CENTER_Y = 2'd1;
    localparam logic [1:0] REG_RADIUS   = 2'd2;
    localparam logic [1:0] REG_SENSE    = 2'd3;

    // sense codes for a single selected sense
    localparam logic [2:0] SENSE_VIS = 3'd1;
    localparam logic [2:0] SENSE_AUD = 3'd2;
    localparam logic [2:0] SENSE_SML = 3'd4;

    typedef enum logic [1:0] {
        CH_NONE,
        CH_VIS,
        CH_AUD,
        CH_SML
    } chan_t;

    typedef struct packed {
        logic [COORD_W-1:0] center_x;
        logic [COORD_W-1:0] center_y;
        logic [COORD_W-1:0] radius;
        logic [2:0]         sense;
    } cfg_t;

    // object data carried down the pipeline
    typedef struct packed {
        logic [2:0]         kind;
        logic [15:0]        ident;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic [EMIS_W-1:0]  emis;
        chan_t              chan;
    } obj_t;

    // square root working pair
    typedef struct packed {
        logic [D2_W-1:0] rem;
        logic [D2_W-1:0] root;
    } sq_t;

    // divider working set
    typedef struct packed {
        logic [NUM_W-1:0]  rem;
        logic [EMIS_W-1:0] quo;
        logic              zero_rad;
    } dv_t;

endpackage
`default_nettype wire

[sv/rqf_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rqf_front
// Sense match, coordinate differences, squares and the radius test.
// Three register stages.
// ----------------------------------------------------------------------------
module rqf_front #(
    parameter int COORD_BITS = 16
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          en,
    input  wire rqf_pkg::cfg_t           cfg,
    input  wire                          in_valid,
    input  wire rqf_pkg::obj_t           in_obj,
    input  wire [2:0]                    in_perc,
    output logic                         out_valid,
    output rqf_pkg::obj_t                out_obj,
    output logic [rqf_pkg::D2_W-1:0]     out_d2
);
    import rqf_pkg::*;

    localparam int CW = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
    localparam logic [COORD_W-1:0] CMASK = COORD_W'((33'(1) << CW) - 33'(1));

    logic [COORD_W-1:0] px, py, cx, cy, rad;
    obj_t               obj_in_m;

    logic               v0_reg, v1_reg, v2_reg;
    obj_t               o0_reg, o1_reg, o2_reg;
    logic [COORD_W-1:0] dx_reg, dy_reg, dx_next, dy_next;
    logic [2*COORD_W-1:0] dx2_reg, dy2_reg, r2_reg;
    logic [D2_W-1:0]    d2_reg;
    logic               keep_next;

    // coordinates taken modulo the coordinate width
    always_comb begin
        px  = in_obj.pos_x & CMASK;
        py  = in_obj.pos_y & CMASK;
        cx  = cfg.center_x & CMASK;
        cy  = cfg.center_y & CMASK;
        rad = cfg.radius & CMASK;
        obj_in_m       = in_obj;
        obj_in_m.pos_x = px;
        obj_in_m.pos_y = py;
        dx_next = (px >= cx) ? px - cx : cx - px;
        dy_next = (py >= cy) ? py - cy : cy - py;
    end

    // radius test on the squares
    assign keep_next = (dx2_reg <= r2_reg) && (dy2_reg <= r2_reg - dx2_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= in_valid && ((in_perc & cfg.sense) != 3'd0);
            v1_reg <= v0_reg;
            v2_reg <= v1_reg && keep_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            o0_reg  <= obj_in_m;
            dx_reg  <= dx_next;
            dy_reg  <= dy_next;
            o1_reg  <= o0_reg;
            dx2_reg <= dx_reg * dx_reg;
            dy2_reg <= dy_reg * dy_reg;
            r2_reg  <= rad * rad;
            o2_reg  <= o1_reg;
            d2_reg  <= D2_W'(dx2_reg) + D2_W'(dy2_reg);
        end
    end

    assign out_valid = v2_reg;
    assign out_obj   = o2_reg;
    assign out_d2    = d2_reg;

endmodule
`default_nettype wire

[sv/rqf_sqrt_pipe.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rqf_sqrt_pipe
// Pipelined digit-by-digit integer square root, four root bits per stage.
// ----------------------------------------------------------------------------
module rqf_sqrt_pipe (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          en,
    input  wire                          in_valid,
    input  wire rqf_pkg::obj_t           in_obj,
    input  wire [rqf_pkg::D2_W-1:0]      in_d2,
    output logic                         out_valid,
    output rqf_pkg::obj_t                out_obj,
    output logic [rqf_pkg::COORD_W-1:0]  out_dist
);
    import rqf_pkg::*;

    localparam int SPS = 4;
    localparam int NST = (SQ_STEPS + SPS - 1) / SPS;

    logic v_reg   [NST];
    obj_t o_reg   [NST];
    sq_t  sq_reg  [NST];

    for (genvar g = 0; g < NST; g++) begin : g_st
        logic vin;
        obj_t oin;
        sq_t  sin;
        sq_t  sq_next;

        if (g == 0) begin : g_first
            assign vin = in_valid;
            assign oin = in_obj;
            assign sin = '{rem: in_d2, root: '0};
        end else begin : g_rest
            assign vin = v_reg[g-1];
            assign oin = o_reg[g-1];
            assign sin = sq_reg[g-1];
        end

        // up to four root bits, highest bit pair first
        always_comb begin
            logic [D2_W-1:0] bitv;
            logic [D2_W-1:0] trial;
            int              step;
            sq_next = sin;
            for (int i = 0; i < SPS; i++) begin
                step = g * SPS + i;
                if (step < SQ_STEPS) begin
                    bitv  = D2_W'(1) << (2 * (SQ_STEPS - 1 - step));
                    trial = sq_next.root + bitv;
                    if (sq_next.rem >= trial) begin
                        sq_next.rem  = sq_next.rem - trial;
                        sq_next.root = (sq_next.root >> 1) + bitv;
                    end else begin
                        sq_next.root = sq_next.root >> 1;
                    end
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[g] <= 1'b0;
            end else if (en) begin
                v_reg[g] <= vin;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                o_reg[g]  <= oin;
                sq_reg[g] <= sq_next;
            end
        end
    end

    assign out_valid = v_reg[NST-1];
    assign out_obj   = o_reg[NST-1];
    // the root never exceeds the radius once the radius test passed
    assign out_dist  = sq_reg[NST-1].root[COORD_W-1:0];

endmodule
`default_nettype wire

[sv/rqf_div_pipe.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rqf_div_pipe
// Falloff strength: emission * (radius - distance) / radius. One multiply
// stage, then a restoring divider with two quotient bits per stage.
// ----------------------------------------------------------------------------
module rqf_div_pipe #(
    parameter int COORD_BITS = 16
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          en,
    input  wire rqf_pkg::cfg_t           cfg,
    input  wire                          in_valid,
    input  wire rqf_pkg::obj_t           in_obj,
    input  wire [rqf_pkg::COORD_W-1:0]   in_dist,
    output logic                         out_valid,
    output rqf_pkg::obj_t                out_obj,
    output logic [rqf_pkg::COORD_W-1:0]  out_dist,
    output logic [rqf_pkg::EMIS_W-1:0]   out_strength
);
    import rqf_pkg::*;

    localparam int CW = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
    localparam logic [COORD_W-1:0] CMASK = COORD_W'((33'(1) << CW) - 33'(1));
    localparam int SPS = 2;
    localparam int NST = EMIS_W / SPS;

    logic [COORD_W-1:0] rad;
    assign rad = cfg.radius & CMASK;

    // multiply stage
    logic               vm_reg;
    obj_t               om_reg;
    logic [COORD_W-1:0] dm_reg;
    dv_t                dvm_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vm_reg <= 1'b0;
        end else if (en) begin
            vm_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            om_reg           <= in_obj;
            dm_reg           <= in_dist;
            dvm_reg.rem      <= in_obj.emis * (rad - in_dist);
            dvm_reg.quo      <= '0;
            dvm_reg.zero_rad <= (rad == '0);
        end
    end

    // divider stages
    logic               v_reg  [NST];
    obj_t               o_reg  [NST];
    logic [COORD_W-1:0] d_reg  [NST];
    dv_t                dv_reg [NST];

    for (genvar g = 0; g < NST; g++) begin : g_st
        logic               vin;
        obj_t               oin;
        logic [COORD_W-1:0] din;
        dv_t                dvin;
        dv_t                dv_next;

        if (g == 0) begin : g_first
            assign vin  = vm_reg;
            assign oin  = om_reg;
            assign din  = dm_reg;
            assign dvin = dvm_reg;
        end else begin : g_rest
            assign vin  = v_reg[g-1];
            assign oin  = o_reg[g-1];
            assign din  = d_reg[g-1];
            assign dvin = dv_reg[g-1];
        end

        // two restoring steps, highest quotient bit first
        always_comb begin
            logic [NUM_W-1:0] sub;
            int               k;
            dv_next = dvin;
            for (int i = 0; i < SPS; i++) begin
                k   = EMIS_W - 1 - (g * SPS + i);
                sub = NUM_W'(rad) << k;
                if (dv_next.rem >= sub) begin
                    dv_next.rem    = dv_next.rem - sub;
                    dv_next.quo[k] = 1'b1;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[g] <= 1'b0;
            end else if (en) begin
                v_reg[g] <= vin;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                o_reg[g]  <= oin;
                d_reg[g]  <= din;
                dv_reg[g] <= dv_next;
            end
        end
    end

    assign out_valid    = v_reg[NST-1];
    assign out_obj      = o_reg[NST-1];
    assign out_dist     = d_reg[NST-1];
    // zero radius: no falloff
    assign out_strength = dv_reg[NST-1].zero_rad ? o_reg[NST-1].emis : dv_reg[NST-1].quo;

endmodule
`default_nettype wire

[sv/radius_query_falloff_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// radius_query_falloff_unit
// Fixed-radius neighbor query with linear strength falloff.
// ----------------------------------------------------------------------------
// Objects enter on the s_ stream, one item per cycle while s_tready is high.
// An object inside the query circle whose perceivable mask meets the sense
// mask leaves on the m_ stream with its distance floor(sqrt(d2)) and the
// falloff strength on the channel of the selected sense; others are dropped.
// Registers are written on cfg_we with cfg_addr / cfg_wdata: 0 center_x,
// 1 center_y, 2 radius, 3 sense. Write them only while the block is idle.
// The stages are 3 of difference, square and radius test, 5 of square
// root at four root bits each, one multiply stage and 4 divider stages at
// two quotient bits each. Throughput is one item per cycle while the
// receiver does not stall. When the receiver stalls the whole pipeline
// holds and s_tready drops; nothing is lost. Synchronous reset empties the
// pipeline and loads center 0, radius 1 and sense visible.
// ----------------------------------------------------------------------------
module radius_query_falloff_unit #(
    parameter int COORD_BITS = 16
) (
    input  wire         aclk,
    input  wire         aresetn,
    // configuration write port
    input  wire         cfg_we,
    input  wire [1:0]   cfg_addr,
    input  wire [15:0]  cfg_wdata,
    // input stream
    input  wire         s_tvalid,
    output logic        s_tready,
    // kind[2:0] ident[18:3] pos_x[34:19] pos_y[50:35] perceivable[53:51]
    // vis_emis[61:54] aud_emis[69:62] sml_emis[77:70]
    input  wire [79:0]  s_tdata,
    // result stream
    output logic        m_tvalid,
    input  wire         m_tready,
    // out_kind[2:0] out_ident[18:3] out_pos_x[34:19] out_pos_y[50:35]
    // distance[66:51] vis_str[74:67] aud_str[82:75] sml_str[90:83]
    output logic [95:0] m_tdata
);
    import rqf_pkg::*;

    cfg_t cfg_reg;
    logic en;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.center_x <= '0;
            cfg_reg.center_y <= '0;
            cfg_reg.radius   <= COORD_W'(1);
            cfg_reg.sense    <= SENSE_VIS;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_CENTER_X: cfg_reg.center_x <= cfg_wdata;
                REG_CENTER_Y: cfg_reg.center_y <= cfg_wdata;
                REG_RADIUS:   cfg_reg.radius   <= cfg_wdata;
                REG_SENSE:    cfg_reg.sense    <= cfg_wdata[2:0];
            endcase
        end
    end

    // pipeline advances while the output slot is empty or being taken
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // unpack the input item and pick the emission of the selected sense
    obj_t in_obj;
    always_comb begin
        in_obj.kind  = s_tdata[2:0];
        in_obj.ident = s_tdata[18:3];
        in_obj.pos_x = s_tdata[34:19];
        in_obj.pos_y = s_tdata[50:35];
        unique case (cfg_reg.sense)
            SENSE_VIS: begin
                in_obj.chan = CH_VIS;
                in_obj.emis = s_tdata[61:54];
            end
            SENSE_AUD: begin
                in_obj.chan = CH_AUD;
                in_obj.emis = s_tdata[69:62];
            end
            SENSE_SML: begin
                in_obj.chan = CH_SML;
                in_obj.emis = s_tdata[77:70];
            end
            default: begin
                in_obj.chan = CH_NONE;
                in_obj.emis = '0;
            end
        endcase
    end

    logic               f_valid, q_valid, d_valid;
    obj_t               f_obj, q_obj, d_obj;
    logic [D2_W-1:0]    f_d2;
    logic [COORD_W-1:0] q_dist, d_dist;
    logic [EMIS_W-1:0]  d_str;

    rqf_front #(.COORD_BITS(COORD_BITS)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_obj    (in_obj),
        .in_perc   (s_tdata[53:51]),
        .out_valid (f_valid),
        .out_obj   (f_obj),
        .out_d2    (f_d2)
    );

    rqf_sqrt_pipe u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (f_valid),
        .in_obj    (f_obj),
        .in_d2     (f_d2),
        .out_valid (q_valid),
        .out_obj   (q_obj),
        .out_dist  (q_dist)
    );

    rqf_div_pipe #(.COORD_BITS(COORD_BITS)) u_div (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (en),
        .cfg          (cfg_reg),
        .in_valid     (q_valid),
        .in_obj       (q_obj),
        .in_dist      (q_dist),
        .out_valid    (d_valid),
        .out_obj      (d_obj),
        .out_dist     (d_dist),
        .out_strength (d_str)
    );

    // pack the result item
    logic [EMIS_W-1:0] vis_s, aud_s, sml_s;
    assign vis_s = (d_obj.chan == CH_VIS) ? d_str : '0;
    assign aud_s = (d_obj.chan == CH_AUD) ? d_str : '0;
    assign sml_s = (d_obj.chan == CH_SML) ? d_str : '0;

    assign m_tvalid = d_valid;
    assign m_tdata  = {5'd0, sml_s, aud_s, vis_s, d_dist,
                       d_obj.pos_y, d_obj.pos_x, d_obj.ident, d_obj.kind};

    // at most one strength channel carries a value
    a_one_channel: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($countones({vis_s != '0, aud_s != '0, sml_s != '0}) <= 1))
        else $error("more than one strength channel nonzero");

    // a reported object lies within the radius
    a_in_radius: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (d_dist <= cfg_reg.radius))
        else $error("reported distance beyond radius");

    // strength never exceeds the emission
    a_str_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (d_str <= d_obj.emis))
        else $error("strength above emission");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule
`default_nettype wire

[dv/rqf_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rqf_checker
// Predicts query results from accepted objects and compares them with the
// result stream of the radius query falloff unit.
// ----------------------------------------------------------------------------
module rqf_checker
    import rqf_pkg::*;
(
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_we,
    input  wire [1:0]   cfg_addr,
    input  wire [15:0]  cfg_wdata,
    input  wire         s_tvalid,
    input  wire         s_tready,
    input  wire [79:0]  s_tdata,
    input  wire         m_tvalid,
    input  wire         m_tready,
    input  wire [95:0]  m_tdata,
    output int          fail_count,
    output int          pending
);

    logic [15:0] cx, cy, rad;
    logic [2:0]  sns;
    logic [95:0] hits_q[$];

    // integer square root, floor
    function automatic logic [31:0] floor_sqrt(input logic [33:0] v);
        logic [33:0] res, bitv, rem;
        res = 0;
        rem = v;
        bitv = 34'h1 << 32;
        while (bitv > rem) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (rem >= res + bitv) begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res[31:0];
    endfunction

    function automatic logic [7:0] fall(input logic [7:0] e, input logic [31:0] d,
                                        input logic [15:0] r);
        logic [31:0] num;
        if (r == 0) return e;
        if (d >= r) return 0;
        num = e * (r - d);
        return 8'(num / r);
    endfunction

    // predict the result of one object; returns 0 when it is dropped
    function automatic bit predict_hit(input logic [79:0] d, output logic [95:0] res);
        logic [15:0] px, py, dx, dy;
        logic [33:0] dx2, dy2, r2;
        logic [31:0] root_d;
        logic [7:0]  vs, as_, ss;
        px = d[34:19];
        py = d[50:35];
        res = '0;
        vs = 0; as_ = 0; ss = 0;
        if ((d[53:51] & sns) == 0) return 0;
        dx = (px >= cx) ? px - cx : cx - px;
        dy = (py >= cy) ? py - cy : cy - py;
        dx2 = dx * dx;
        dy2 = dy * dy;
        r2 = rad * rad;
        if (dx2 > r2) return 0;
        if (dy2 > r2 - dx2) return 0;
        root_d = floor_sqrt(dx2 + dy2);
        if (sns == SENSE_VIS) vs = fall(d[61:54], root_d, rad);
        else if (sns == SENSE_AUD) as_ = fall(d[69:62], root_d, rad);
        else if (sns == SENSE_SML) ss = fall(d[77:70], root_d, rad);
        res = {5'b0, ss, as_, vs, root_d[15:0], py, px, d[18:3], d[2:0]};
        return 1;
    endfunction

    always @(posedge aclk) begin
        logic [95:0] exp_r, got;
        if (!aresetn) begin
            cx <= 0; cy <= 0; rad <= 1; sns <= SENSE_VIS;
            hits_q.delete();
            fail_count <= 0;
            pending <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_CENTER_X: cx <= cfg_wdata;
                    REG_CENTER_Y: cy <= cfg_wdata;
                    REG_RADIUS:   rad <= cfg_wdata;
                    REG_SENSE:    sns <= cfg_wdata[2:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready && predict_hit(s_tdata, exp_r))
                hits_q = {hits_q, exp_r};
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (hits_q.size() == 0) begin
                    $display("%0t: unexpected result: expected none actual %h",
                             $time, got);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_r = hits_q.pop_front();
                    if (got[90:0] !== exp_r[90:0]) begin
                        $display("%0t: result mismatch: expected %h actual %h",
                                 $time, exp_r[90:0], got[90:0]);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= hits_q.size();
        end
    end

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the radius query falloff unit.
// ----------------------------------------------------------------------------
// Directed objects cover field extremes and the sense and radius corner
// cases, then random objects run under several settings with random gaps on
// both sides, one long receiver stall and a drain before each new setting.
// ----------------------------------------------------------------------------
module tb;
    import rqf_pkg::*;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_we = 0;
    logic [1:0]  cfg_addr = REG_CENTER_X;
    logic [15:0] cfg_wdata = 0;
    logic        s_tvalid = 0;
    wire         s_tready;
    logic [79:0] s_tdata = 0;
    wire         m_tvalid;
    logic        m_tready = 0;
    wire  [95:0] m_tdata;
    int          fail_count, pending;
    bit          hold_long = 0;

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    radius_query_falloff_unit dut (.*);

    rqf_checker chk (.*);

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
        return 0;
    endfunction

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        int n;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_long) begin
                m_tready <= 0;
                repeat (200) @(negedge aclk);
                hold_long = 0;
            end
            n = $urandom_range(0, 3) == 0 ? gap_len() : 0;
            if (n > 0) begin
                m_tready <= 0;
                repeat (n) @(negedge aclk);
            end
            m_tready <= 1;
        end
    end

    task automatic cfg_write(input logic [1:0] a, input logic [15:0] v);
        @(negedge aclk);
        cfg_we <= 1; cfg_addr <= a; cfg_wdata <= v;
        @(negedge aclk);
        cfg_we <= 0;
    endtask

    task automatic wait_idle();
        while (pending != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    task automatic set_query(input logic [15:0] x, y, r, input logic [2:0] s);
        wait_idle();
        cfg_write(REG_CENTER_X, x);
        cfg_write(REG_CENTER_Y, y);
        cfg_write(REG_RADIUS, r);
        cfg_write(REG_SENSE, {13'b0, s});
    endtask

    // offer one object, hold until accepted; gaps come before it
    task automatic send_obj(input logic [79:0] d, input bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        if (g > 0) begin
            s_tvalid <= 0;
            repeat (g) @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic [79:0] mk_obj(input logic [2:0] k, input logic [15:0] id,
            input logic [15:0] x, y, input logic [2:0] p, input logic [7:0] ve, le, se);
        return {2'b0, se, le, ve, p, y, x, id, k};
    endfunction

    // random object, mostly near the current center
    function automatic logic [79:0] rnd_obj(input logic [15:0] x0, y0, r);
        logic [15:0] x, y;
        int span;
        span = r + 2;
        if ($urandom_range(0, 4) == 0) begin
            x = 16'($urandom); y = 16'($urandom);
        end else begin
            x = 16'(x0 + $urandom_range(0, 2 * span) - span);
            y = 16'(y0 + $urandom_range(0, 2 * span) - span);
        end
        return mk_obj(3'($urandom), 16'($urandom), x, y, 3'($urandom),
                      8'($urandom), 8'($urandom), 8'($urandom));
    endfunction

    task automatic rnd_phase(input logic [15:0] x0, y0, r, input logic [2:0] s,
                             input int n);
        set_query(x0, y0, r, s);
        repeat (n) send_obj(rnd_obj(x0, y0, r), 1);
        s_tvalid <= 0;
    endtask

    initial begin
        repeat (11) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // reset settings: center 0, radius 1, visible
        send_obj(mk_obj(7, 16'hFFFF, 0, 0, 3'd1, 255, 255, 255), 0);
        send_obj(mk_obj(0, 0, 16, 0, 3'd7, 200, 1, 1), 0);
        send_obj(mk_obj(5, 1, 1, 0, 3'd1, 255, 0, 0), 0);
        send_obj(mk_obj(2, 2, 1, 1, 3'd1, 255, 0, 0), 0);
        send_obj(mk_obj(3, 3, 0, 0, 3'd6, 255, 0, 0), 0);
        s_tvalid <= 0;
        // radius zero: only the exact center
        set_query(16'h1000, 16'h2000, 0, SENSE_AUD);
        send_obj(mk_obj(1, 10, 16'h1000, 16'h2000, 3'd2, 0, 99, 0), 0);
        send_obj(mk_obj(1, 11, 16'h1001, 16'h2000, 3'd2, 0, 99, 0), 0);
        s_tvalid <= 0;
        // full radius, corners, smell
        set_query(0, 0, 16'hFFFF, SENSE_SML);
        send_obj(mk_obj(4, 20, 16'hFFFF, 0, 3'd4, 0, 0, 255), 0);
        send_obj(mk_obj(4, 21, 16'hFFFF, 16'hFFFF, 3'd7, 0, 0, 255), 0);
        send_obj(mk_obj(4, 22, 16'hB504, 16'hB504, 3'd4, 0, 0, 255), 0);
        send_obj(mk_obj(4, 23, 100, 100, 3'd4, 0, 0, 128), 0);
        s_tvalid <= 0;
        // center at max, several senses, then zero sense
        set_query(16'hFFFF, 16'hFFFF, 300, 3'd5);
        send_obj(mk_obj(6, 30, 16'hFFF0, 16'hFF00, 3'd1, 77, 88, 99), 0);
        send_obj(mk_obj(6, 31, 16'hFFFF, 16'hFFFF, 3'd4, 77, 88, 99), 0);
        s_tvalid <= 0;
        set_query(16'hFFFF, 16'hFFFF, 300, 3'd0);
        send_obj(mk_obj(6, 32, 16'hFFFF, 16'hFFFF, 3'd7, 77, 88, 99), 0);
        s_tvalid <= 0;

        rnd_phase(16'h8000, 16'h8000, 16'd1000, SENSE_VIS, 200);
        // receiver holds off while the sender keeps offering
        hold_long = 1;
        set_query(16'h0100, 16'hFF00, 16'd400, SENSE_AUD);
        hold_long = 1;
        repeat (150) send_obj(rnd_obj(16'h0100, 16'hFF00, 400), 0);
        s_tvalid <= 0;
        rnd_phase(16'h4000, 16'h1234, 16'd40, SENSE_SML, 150);
        rnd_phase(16'($urandom), 16'($urandom), 16'hFFFF, 3'd7, 100);
        rnd_phase(16'h0000, 16'h0000, 16'd5000, 3'd3, 100);
        rnd_phase(16'hFFFF, 16'h0000, 16'd1, SENSE_VIS, 50);
        rnd_phase(16'($urandom), 16'($urandom), 16'($urandom_range(1, 3000)),
                  SENSE_VIS, 200);

        wait_idle();
        repeat (30) @(negedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule
